FILE: rtl/core/udp_cks_pkg.sv
// Shared types, constants and the ones-complement fold for the UDP/IPv4
// transmit header checksum block. No dependencies.
package udp_cks_pkg;

	localparam int MAX_FRAME_BYTES = 4096;
	localparam int HDR_BYTES       = 42;
	localparam int CNT_W           = 13;
	localparam int SUM_W           = 28;
	localparam int QDEPTH          = 2;
	localparam int QPTR_W          = $clog2(QDEPTH);

	localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] MAX_PAYLOAD = CNT_W'(MAX_FRAME_BYTES - HDR_BYTES);
	localparam logic [CNT_W-1:0] HDR_LEN     = CNT_W'(HDR_BYTES);

	localparam logic [15:0] IP_VER_IHL   = 16'h4500;
	localparam logic [15:0] IP_TTL_PROTO = 16'h4011;
	localparam logic [15:0] PROTO_UDP    = 16'h0011;
	localparam logic [15:0] CKS_ALL_ONES = 16'hFFFF;

	typedef enum logic [0:0] {
		REG_SRC_IP   = 1'b0,
		REG_SRC_PORT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        last;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [11:0] ip_total_length;
		logic [11:0] udp_length;
		logic [15:0] ip_checksum;
		logic [15:0] udp_checksum;
		logic [15:0] udp_source_port;
		logic [12:0] frame_length;
	} out_item_t;

	// one finished packet handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [7:0]       high_byte;
		logic [CNT_W-1:0] count;
		logic [31:0]      dst_ip;
		logic [15:0]      dst_port;
	} job_t;

	// end-around carry fold of an unfolded sum down to 16 bits
	function automatic logic [15:0] ones_fold(input logic [SUM_W:0] x);
		logic [16:0] t;
		begin
			t = {1'b0, x[15:0]} + 17'(x[SUM_W:16]);
			return t[15:0] + 16'(t[16]);
		end
	endfunction

endpackage

FILE: rtl/core/udp_ipv4_tx_header_checksum.sv
// Top level of the UDP/IPv4 transmit header checksum block: config
// registers, front end, job queue, back end. Depends on udp_cks_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------
//  in       | input     | in_valid / in_ready  | in_item (in_item_t)
//  out      | output    | out_valid / out_ready| out_item (out_item_t)
//  cfg      | input     | cfg_wen              | cfg_index, cfg_data
//
// One payload byte per cycle while in_ready is high; the front adds each
// byte pair as a word into the running sum when its second byte is taken.
// A last transaction passes a two-entry queue and a three-stage back
// pipeline. in_ready drops only while the job queue is full. Reset clears
// all control state and both config registers; no clearing pass is needed.
module udp_ipv4_tx_header_checksum import udp_cks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] src_ip_q;
	logic [15:0] src_port_q;
	logic        q_full, q_push, q_pop, q_not_empty;
	job_t        q_job, q_head;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ip_q   <= '0;
			src_port_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_IP: begin
					src_ip_q <= cfg_data;
				end
				REG_SRC_PORT: begin
					src_port_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	udp_cks_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	udp_cks_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	udp_cks_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_ip      (src_ip_q),
		.src_port    (src_port_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

	// oversized packets carry nothing but the status flag
	a_over_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status |->
			out_item.udp_checksum == '0 && out_item.frame_length == '0)
		else $error("oversize result carries header fields");

	// a sent UDP checksum is never zero
	a_udp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.status |-> out_item.udp_checksum != '0)
		else $error("zero UDP checksum sent");

	// frame and IP lengths differ by the Ethernet header
	a_len_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.status |->
			out_item.frame_length == 13'(out_item.ip_total_length) + 13'd14)
		else $error("frame length and IP length disagree");

	// a full queue is the only reason to back-pressure the input
	a_ready_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full && q_not_empty)
		else $error("input stalled with room in queue");

endmodule

FILE: rtl/core/udp_cks_front.sv
// Front end: accepts payload transactions, keeps the running word sum and
// byte count, and pushes one job per packet. Depends on udp_cks_pkg.
module udp_cks_front import udp_cks_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     q_full,
	output logic     q_push,
	output job_t     q_job
);

	logic [SUM_W-1:0] sum_q, sum_nx;
	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic [7:0]       hb_q, hb_nx;
	logic             take;
	logic             acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	// byte accumulation; counter saturates and stops summing
	always_comb begin
		take   = in_item.byte_valid && (cnt_q != COUNT_MAX);
		sum_nx = sum_q;
		hb_nx  = hb_q;
		if (take && cnt_q[0]) begin
			sum_nx = sum_q + SUM_W'({hb_q, in_item.payload_byte});
		end else if (take) begin
			hb_nx = in_item.payload_byte;
		end
		cnt_nx = cnt_q + CNT_W'(take);
	end

	assign q_push = acc && in_item.last;
	assign q_job  = '{sum: sum_nx, high_byte: hb_nx, count: cnt_nx,
		dst_ip: in_item.dst_ip, dst_port: in_item.dst_port};

	// packet state, cleared once the job is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			hb_q  <= '0;
		end else if (acc && in_item.last) begin
			sum_q <= '0;
			cnt_q <= '0;
			hb_q  <= '0;
		end else if (acc) begin
			sum_q <= sum_nx;
			cnt_q <= cnt_nx;
			hb_q  <= hb_nx;
		end
	end

endmodule

FILE: rtl/core/udp_cks_queue.sv
// Short job queue between front and back end.
// Depends on udp_cks_pkg.
module udp_cks_queue import udp_cks_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t head
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

endmodule

FILE: rtl/core/udp_cks_back.sv
// Back end: three-stage header pipeline (operand sums, wide sums, fold
// and output register). Depends on udp_cks_pkg.
module udp_cks_back import udp_cks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] src_ip,
	input  logic [15:0] src_port,
	input  logic        q_not_empty,
	input  job_t        q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	logic en;

	logic             v_s1, over_s1;
	logic [SUM_W-1:0] psum_s1;
	logic [17:0]      addr_s1, port_s1;
	logic [13:0]      ulen_s1, tlen_s1;
	logic [15:0]      sport_s1;
	logic [CNT_W-1:0] cnt_s1;

	logic             v_s2, over_s2;
	logic [SUM_W:0]   usum_s2;
	logic [18:0]      isum_s2;
	logic [13:0]      ulen_s2, tlen_s2;
	logic [15:0]      sport_s2;
	logic [CNT_W-1:0] cnt_s2;

	logic             out_valid_q;
	out_item_t        out_q;

	logic [SUM_W-1:0] psum_c;
	logic [17:0]      addr_c, port_c;
	logic [13:0]      ulen_c, tlen_c;
	logic [15:0]      sport_c;
	logic [15:0]      ucks_c, icks_c;
	out_item_t        res_c;

	// whole pipeline moves when the output register is free or taken
	assign en        = !out_valid_q || out_ready;
	assign q_pop     = en && q_not_empty;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// stage 1 operands
	always_comb begin
		psum_c  = q_head.sum + (q_head.count[0] ?
			SUM_W'({q_head.high_byte, 8'h00}) : '0);
		addr_c  = 18'(src_ip[31:16]) + 18'(src_ip[15:0])
			+ 18'(q_head.dst_ip[31:16]) + 18'(q_head.dst_ip[15:0]);
		sport_c = (src_port == '0) ? q_head.dst_port : src_port;
		ulen_c  = 14'(q_head.count) + 14'd8;
		tlen_c  = 14'(q_head.count) + 14'd28;
		port_c  = 18'(sport_c) + 18'(q_head.dst_port) + 18'(PROTO_UDP)
			+ 18'({ulen_c, 1'b0});
	end

	// stage 3 fold, complement and oversize masking
	always_comb begin
		ucks_c = ~ones_fold(usum_s2);
		icks_c = ~ones_fold((SUM_W+1)'(isum_s2));
		if (ucks_c == '0) begin
			ucks_c = CKS_ALL_ONES;
		end
		res_c = '0;
		if (over_s2) begin
			res_c.status = 1'b1;
		end else begin
			res_c.ip_total_length = tlen_s2[11:0];
			res_c.udp_length      = ulen_s2[11:0];
			res_c.ip_checksum     = icks_c;
			res_c.udp_checksum    = ucks_c;
			res_c.udp_source_port = sport_s2;
			res_c.frame_length    = cnt_s2 + HDR_LEN;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= q_not_empty;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			over_s1  <= q_head.count > MAX_PAYLOAD;
			psum_s1  <= psum_c;
			addr_s1  <= addr_c;
			port_s1  <= port_c;
			ulen_s1  <= ulen_c;
			tlen_s1  <= tlen_c;
			sport_s1 <= sport_c;
			cnt_s1   <= q_head.count;

			over_s2  <= over_s1;
			usum_s2  <= (SUM_W+1)'(psum_s1) + (SUM_W+1)'(addr_s1)
				+ (SUM_W+1)'(port_s1);
			isum_s2  <= 19'(IP_VER_IHL) + 19'(IP_TTL_PROTO) + 19'(tlen_s1)
				+ 19'(addr_s1);
			ulen_s2  <= ulen_s1;
			tlen_s2  <= tlen_s1;
			sport_s2 <= sport_s1;
			cnt_s2   <= cnt_s1;

			out_q    <= res_c;
		end
	end

endmodule
